[rtl/strided_nd_address_generator_top_defines.svh]
// Assertion macros shared by the address generator RTL.
`ifndef STRIDED_ND_ADDRESS_GENERATOR_TOP_DEFINES_SVH
`define STRIDED_ND_ADDRESS_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SNDAG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define SNDAG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SNDAG_ASSERT(lbl, clk, rst_n, prop, msg)
`define SNDAG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/sndag_pkg.sv]
`timescale 1ns / 1ps

package sndag_pkg;

  localparam int NDim       = 4;
  localparam int DimsDefault = 4;

  localparam int SizeW   = 16;
  localparam int StrideW = 24;
  localparam int ProdW   = SizeW + StrideW;
  localparam int OffsetW = 42;
  localparam int CfgIdxW = 4;
  localparam int CfgDataW = StrideW;

  typedef logic [SizeW-1:0]   idx_t;
  typedef logic [StrideW-1:0] stride_t;
  typedef logic [OffsetW-1:0] offset_t;
  typedef idx_t    [NDim-1:0] idx_vec_t;
  typedef stride_t [NDim-1:0] stride_vec_t;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegSizeDim0   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegSizeDim1   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegSizeDim2   = 4'd2;
  localparam logic [CfgIdxW-1:0] RegSizeDim3   = 4'd3;
  localparam logic [CfgIdxW-1:0] RegStrideDim0 = 4'd4;
  localparam logic [CfgIdxW-1:0] RegStrideDim1 = 4'd5;
  localparam logic [CfgIdxW-1:0] RegStrideDim2 = 4'd6;
  localparam logic [CfgIdxW-1:0] RegStrideDim3 = 4'd7;

  localparam idx_t    SizeReset        = 16'd1;
  localparam stride_t StrideReset      = 24'd0;
  localparam stride_t StrideInnerReset = 24'd1;

  // One walk position as handed from the odometer to the offset pipeline.
  typedef struct packed {
    idx_vec_t idx;
    logic     last;
  } step_t;

endpackage

[rtl/sndag_if.sv]
`timescale 1ns / 1ps

interface sndag_in_if
  import sndag_pkg::*;
();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface sndag_out_if
  import sndag_pkg::*;
();
  logic    valid;
  logic    ready;
  offset_t offset;
  idx_t    index_0;
  idx_t    index_1;
  idx_t    index_2;
  idx_t    index_3;
  logic    last_of_run;

  modport source (output valid, output offset, output index_0, output index_1,
                  output index_2, output index_3, output last_of_run, input ready);
  modport sink   (input valid, input offset, input index_0, input index_1,
                  input index_2, input index_3, input last_of_run, output ready);
endinterface

[rtl/sndag_odometer.sv]
`timescale 1ns / 1ps
`include "strided_nd_address_generator_top_defines.svh"

module sndag_odometer
  import sndag_pkg::*;
#(
  parameter int Dims = DimsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic     restart_i,
  input  idx_vec_t size_i,
  output step_t    step_o
);

  localparam int FirstActive = NDim - Dims;

  idx_vec_t         pos_q, pos_d;
  idx_vec_t         pos_eff;
  logic [NDim-1:0]  at_end;
  logic             carry;

  always_comb begin
    for (int d = 0; d < NDim; d++) begin
      pos_eff[d] = (restart_i || d < FirstActive) ? '0 : pos_q[d];
      // A size of zero behaves as one; an index past the extent counts as finished.
      at_end[d]  = (d < FirstActive) ||
                   (({1'b0, pos_eff[d]} + {{SizeW{1'b0}}, 1'b1}) >= {1'b0, size_i[d]});
    end
  end

  // Odometer advance, innermost first.
  always_comb begin
    carry = 1'b1;
    for (int d = NDim - 1; d >= 0; d--) begin
      if (d < FirstActive) begin
        pos_d[d] = '0;
      end else if (carry) begin
        if (at_end[d]) begin
          pos_d[d] = '0;
        end else begin
          pos_d[d] = pos_eff[d] + idx_t'(1);
          carry    = 1'b0;
        end
      end else begin
        pos_d[d] = pos_eff[d];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
    end
  end

  assign step_o.idx  = pos_eff;
  assign step_o.last = &at_end;

  `SNDAG_ASSERT(a_wrap_after_last, clk_i, rst_ni, accept_i && step_o.last |=> pos_q == '0, "walk did not wrap after last element")
  `SNDAG_ASSERT(a_advance, clk_i, rst_ni, accept_i && !step_o.last |=> pos_q != $past(pos_eff), "walk did not advance")
  `SNDAG_ASSERT_ALWAYS(a_outer_idle, clk_i, (Dims == NDim) || (pos_q[0] == '0), "inactive dimension moved")

endmodule

[rtl/sndag_offset_pipe.sv]
`timescale 1ns / 1ps
`include "strided_nd_address_generator_top_defines.svh"

module sndag_offset_pipe
  import sndag_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  step_t       step_i,
  input  stride_vec_t stride_i,
  output logic        valid_o,
  input  logic        ready_i,
  output step_t       step_o,
  output offset_t     offset_o
);

  localparam int PairW = ProdW + 1;

  logic in_v_q, out_v_q;
  logic en_in, en_out;

  step_t            in_step_q, out_step_q;
  logic [ProdW-1:0] prod [NDim];
  logic [PairW-1:0] pair_hi, pair_lo;
  offset_t          sum;
  offset_t          offset_q;

  // A stage moves when it is empty or the one after it moves.
  assign en_out  = !out_v_q || ready_i;
  assign en_in   = !in_v_q || en_out;
  assign ready_o = en_in;

  always_comb begin
    for (int d = 0; d < NDim; d++) begin
      prod[d] = ProdW'(in_step_q.idx[d]) * ProdW'(stride_i[d]);
    end
    pair_hi = {1'b0, prod[0]} + {1'b0, prod[1]};
    pair_lo = {1'b0, prod[2]} + {1'b0, prod[3]};
    sum     = OffsetW'({1'b0, pair_hi} + {1'b0, pair_lo});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_in)  in_v_q  <= valid_i;
      if (en_out) out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in) begin
      in_step_q <= step_i;
    end
    if (en_out) begin
      out_step_q <= in_step_q;
      offset_q   <= sum;
    end
  end

  assign valid_o  = out_v_q;
  assign step_o   = out_step_q;
  assign offset_o = offset_q;

  `SNDAG_ASSERT(a_stall_only_when_full, clk_i, rst_ni, !ready_o |-> (out_v_q && !ready_i), "input stalled with room in pipe")
  `SNDAG_ASSERT(a_no_loss, clk_i, rst_ni, out_v_q && !ready_i |=> out_v_q && $stable(offset_q), "held result lost")

endmodule

[rtl/strided_nd_address_generator_top.sv]
// Strided N-dimensional address generator.
// Each item taken on in_i (field restart) yields exactly one item on out_o:
// the current per-dimension indices (index_0 outermost), the element offset
// sum(index * stride) modulo 2^42, and last_of_run on the final element of
// the walk, after which the walk wraps to all-zero. restart = 1 zeroes the
// walk before the item is formed.
// Sizes and strides are written on the cfg_we_i / cfg_idx_i / cfg_data_i port
// (indexes 0..3 sizes, 4..7 strides, others ignored); the user writes them only
// while no item is in flight, which the block itself does not enforce.
// Only the innermost Dims dimensions walk; the others stay at index 0.
// An accepted item lands in the input register; then the four 16x24 products
// are summed into the result register, which drives out_o.valid.
// Throughput is one item per cycle while out_o.ready stays high; the odometer
// carry chain updates the position in the same cycle an item is accepted.
// When out_o.ready is low, the held result stays on out_o and one more item
// is taken into the input register before in_i.ready drops.
// Reset clears the walk position to zero, empties the pipeline and loads
// sizes of 1, strides of 0 and an innermost stride of 1.
`timescale 1ns / 1ps

module strided_nd_address_generator_top
  import sndag_pkg::*;
#(
  parameter int Dims = DimsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sndag_in_if.sink            in_i,
  sndag_out_if.source         out_o
);

  idx_vec_t    size_q;
  stride_vec_t stride_q;
  logic        accept;
  step_t       step_in, step_out;
  offset_t     offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= {NDim{SizeReset}};
      stride_q    <= {StrideInnerReset, {(NDim-1){StrideReset}}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSizeDim0:   size_q[0]   <= cfg_data_i[SizeW-1:0];
        RegSizeDim1:   size_q[1]   <= cfg_data_i[SizeW-1:0];
        RegSizeDim2:   size_q[2]   <= cfg_data_i[SizeW-1:0];
        RegSizeDim3:   size_q[3]   <= cfg_data_i[SizeW-1:0];
        RegStrideDim0: stride_q[0] <= cfg_data_i;
        RegStrideDim1: stride_q[1] <= cfg_data_i;
        RegStrideDim2: stride_q[2] <= cfg_data_i;
        RegStrideDim3: stride_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = in_i.valid && in_i.ready;

  sndag_odometer #(
    .Dims (Dims)
  ) u_odometer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .restart_i (in_i.restart),
    .size_i    (size_q),
    .step_o    (step_in)
  );

  sndag_offset_pipe u_offset_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .step_i   (step_in),
    .stride_i (stride_q),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .step_o   (step_out),
    .offset_o (offset)
  );

  assign out_o.offset      = offset;
  assign out_o.index_0     = step_out.idx[0];
  assign out_o.index_1     = step_out.idx[1];
  assign out_o.index_2     = step_out.idx[2];
  assign out_o.index_3     = step_out.idx[3];
  assign out_o.last_of_run = step_out.last;

endmodule

[test/strided_nd_address_generator_top_test.sv]
`timescale 1ns / 1ps

module strided_nd_address_generator_top_test;
  import sndag_pkg::*;

  localparam int DutDims = DimsDefault;
  localparam int CycleLimit = 400000;
  localparam int RandomPhases = 10;
  localparam int ItemsPerPhase = 95;
  localparam logic [CfgIdxW-1:0] RegFirstUnused = 4'd8;
  localparam logic [CfgIdxW-1:0] RegLastUnused = 4'd15;

  typedef struct packed {
    offset_t offset;
    idx_t    index_0;
    idx_t    index_1;
    idx_t    index_2;
    idx_t    index_3;
    logic    last_of_run;
  } addr_item_t;

  typedef struct {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_data;
    logic                restart;
    logic                typed;
    logic                typed_last;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  sndag_in_if  in_if ();
  sndag_out_if out_if ();

  strided_nd_address_generator_top #(
    .Dims(DutDims)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walk state and register copy of the address generator.
  idx_t    walk_pos   [NDim];
  idx_t    size_reg   [NDim];
  stride_t stride_reg [NDim];

  addr_item_t pending_addr_q[$];
  script_row_t directed_script[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic logic dim_walks(input int d);
    return d >= NDim - DutDims;
  endfunction

  // A dimension is done when its next index would reach the extent;
  // a size of zero or an index already past the extent counts as done.
  function automatic logic dim_done(input int d);
    if (!dim_walks(d)) return 1'b1;
    return (32'(walk_pos[d]) + 32'd1) >= 32'(size_reg[d]);
  endfunction

  function automatic addr_item_t step_walk(input logic restart);
    addr_item_t r;
    offset_t sum;
    logic all_done;
    logic carry;
    idx_t cur [NDim];
    if (restart) begin
      for (int d = 0; d < NDim; d++) walk_pos[d] = '0;
    end
    sum = '0;
    all_done = 1'b1;
    for (int d = 0; d < NDim; d++) begin
      if (!dim_walks(d)) walk_pos[d] = '0;
      sum += offset_t'(walk_pos[d]) * offset_t'(stride_reg[d]);
      if (!dim_done(d)) all_done = 1'b0;
      cur[d] = walk_pos[d];
    end
    r.offset      = sum;
    r.index_0     = cur[0];
    r.index_1     = cur[1];
    r.index_2     = cur[2];
    r.index_3     = cur[3];
    r.last_of_run = all_done;
    // Odometer advance, innermost first; stop at the first dimension that counts up.
    carry = 1'b1;
    for (int d = NDim - 1; d >= 0; d--) begin
      if (!dim_walks(d)) begin
        walk_pos[d] = '0;
      end else if (carry) begin
        if (dim_done(d)) begin
          walk_pos[d] = '0;
        end else begin
          walk_pos[d] = walk_pos[d] + 16'd1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic void apply_reg_write(input logic [CfgIdxW-1:0] a,
                                          input logic [CfgDataW-1:0] v);
    case (a)
      RegSizeDim0, RegSizeDim1, RegSizeDim2, RegSizeDim3: begin
        size_reg[a - RegSizeDim0] = v[SizeW-1:0];
      end
      RegStrideDim0, RegStrideDim1, RegStrideDim2, RegStrideDim3: begin
        stride_reg[a - RegStrideDim0] = v;
      end
      default: ;
    endcase
  endfunction

  function automatic script_row_t cfg_row(input logic [CfgIdxW-1:0] a,
                                          input logic [CfgDataW-1:0] v);
    script_row_t r;
    r = '{default: '0};
    r.is_cfg   = 1'b1;
    r.reg_idx  = a;
    r.reg_data = v;
    return r;
  endfunction

  function automatic script_row_t walk_row(input logic restart);
    script_row_t r;
    r = '{default: '0};
    r.restart = restart;
    return r;
  endfunction

  // Expected result is the all-zero position with offset zero.
  function automatic script_row_t zero_row(input logic restart, input logic last);
    script_row_t r;
    r = '{default: '0};
    r.restart    = restart;
    r.typed      = 1'b1;
    r.typed_last = last;
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] a, input logic [CfgDataW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= a;
    cfg_data <= v;
    @(posedge clk_i);
    apply_reg_write(a, v);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_addr_q.size() != 0) @(negedge clk_i);
  endtask

  // Called at a falling edge; valid stays high on return for a back-to-back item.
  task automatic send_item(input logic restart, input logic typed, input logic typed_last);
    addr_item_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid   <= 1'b0;
      in_if.restart <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk_i); while (!in_if.ready);
    want = step_walk(restart);
    if (typed) begin
      want = '0;
      want.last_of_run = typed_last;
    end
    pending_addr_q.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic program_phase(input int kind);
    logic [SizeW-1:0] sz;
    stride_t st;
    int pick;
    for (int d = 0; d < NDim; d++) begin
      pick = $urandom_range(15);
      if (kind == 0) sz = 16'hFFFF;
      else if (kind == 1) sz = '0;
      else if (pick < 2) sz = '0;
      else if (pick == 2) sz = SizeW'($urandom_range(65535, 1000));
      else if (pick == 3) sz = SizeW'($urandom_range(9, 4));
      else sz = SizeW'($urandom_range(3, 1));
      // Upper data bits are junk for a size register.
      write_reg(CfgIdxW'(RegSizeDim0 + d), {8'($urandom_range(255)), sz});
    end
    for (int d = 0; d < NDim; d++) begin
      pick = $urandom_range(9);
      if (kind == 0) st = 24'hFFFFFF;
      else if (kind == 1) st = '0;
      else if (pick < 2) st = '0;
      else if (pick == 2) st = 24'hFFFFFF;
      else if (pick < 6) st = StrideW'($urandom_range(64, 1));
      else st = StrideW'($urandom());
      write_reg(CfgIdxW'(RegStrideDim0 + d), st);
    end
    write_reg(CfgIdxW'($urandom_range(RegLastUnused, RegFirstUnused)),
              CfgDataW'($urandom()));
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    addr_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_addr_q.size() == 0) begin
        $display("%0t: result with none pending: offset %h last %b", $time,
                 out_if.offset, out_if.last_of_run);
        mismatch_count++;
      end else begin
        want = pending_addr_q.pop_front();
        if (out_if.offset !== want.offset) begin
          $display("%0t: offset expected %h actual %h", $time, want.offset, out_if.offset);
          mismatch_count++;
        end
        if (out_if.index_0 !== want.index_0) begin
          $display("%0t: index_0 expected %h actual %h", $time, want.index_0, out_if.index_0);
          mismatch_count++;
        end
        if (out_if.index_1 !== want.index_1) begin
          $display("%0t: index_1 expected %h actual %h", $time, want.index_1, out_if.index_1);
          mismatch_count++;
        end
        if (out_if.index_2 !== want.index_2) begin
          $display("%0t: index_2 expected %h actual %h", $time, want.index_2, out_if.index_2);
          mismatch_count++;
        end
        if (out_if.index_3 !== want.index_3) begin
          $display("%0t: index_3 expected %h actual %h", $time, want.index_3, out_if.index_3);
          mismatch_count++;
        end
        if (out_if.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run,
                   out_if.last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    for (int d = 0; d < NDim; d++) begin
      walk_pos[d]   = '0;
      size_reg[d]   = SizeReset;
      stride_reg[d] = StrideReset;
    end
    stride_reg[NDim-1] = StrideInnerReset;

    // Out of reset every size is 1, so each item is the last one.
    directed_script.push_back(zero_row(1'b0, 1'b1));
    directed_script.push_back(zero_row(1'b1, 1'b1));
    // Small walk with a broadcast dimension and a maximal inner stride.
    directed_script.push_back(cfg_row(RegSizeDim3, 24'd3));
    directed_script.push_back(cfg_row(RegSizeDim2, 24'd2));
    directed_script.push_back(cfg_row(RegSizeDim1, 24'd2));
    directed_script.push_back(cfg_row(RegStrideDim3, 24'hFFFFFF));
    directed_script.push_back(cfg_row(RegStrideDim2, 24'd3));
    directed_script.push_back(cfg_row(RegStrideDim1, 24'd0));
    for (int i = 0; i < 7; i++) directed_script.push_back(walk_row(1'b0));
    directed_script.push_back(zero_row(1'b1, 1'b0));
    // Largest sizes and strides.
    directed_script.push_back(cfg_row(RegSizeDim0, 24'h00FFFF));
    directed_script.push_back(cfg_row(RegSizeDim1, 24'h00FFFF));
    directed_script.push_back(cfg_row(RegSizeDim2, 24'h00FFFF));
    directed_script.push_back(cfg_row(RegSizeDim3, 24'h00FFFF));
    directed_script.push_back(cfg_row(RegStrideDim0, 24'hFFFFFF));
    directed_script.push_back(cfg_row(RegStrideDim1, 24'hFFFFFF));
    directed_script.push_back(cfg_row(RegStrideDim2, 24'hFFFFFF));
    for (int i = 0; i < 3; i++) directed_script.push_back(walk_row(1'b0));
    directed_script.push_back(zero_row(1'b1, 1'b0));
    directed_script.push_back(walk_row(1'b0));
    // Zero sizes act as 1 and leave the current indices past the extent.
    directed_script.push_back(cfg_row(RegSizeDim0, 24'hFF0000));
    directed_script.push_back(cfg_row(RegSizeDim1, 24'h000000));
    directed_script.push_back(cfg_row(RegSizeDim2, 24'hAB0000));
    directed_script.push_back(cfg_row(RegSizeDim3, 24'h000000));
    directed_script.push_back(walk_row(1'b0));
    directed_script.push_back(zero_row(1'b0, 1'b1));
    // Index outside the register list changes nothing.
    directed_script.push_back(cfg_row(RegFirstUnused, 24'hFFFFFF));
    directed_script.push_back(cfg_row(RegLastUnused, 24'h000002));
    directed_script.push_back(walk_row(1'b0));
    // Transposed view: swapped sizes and strides on the two inner dimensions.
    directed_script.push_back(cfg_row(RegSizeDim2, 24'd3));
    directed_script.push_back(cfg_row(RegSizeDim3, 24'd2));
    directed_script.push_back(cfg_row(RegStrideDim2, 24'd1));
    directed_script.push_back(cfg_row(RegStrideDim3, 24'd3));
    for (int i = 0; i < 4; i++) directed_script.push_back(walk_row(1'b0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_script[i]) begin
      if (directed_script[i].is_cfg) begin
        wait_idle();
        write_reg(directed_script[i].reg_idx, directed_script[i].reg_data);
      end else begin
        cfg_we <= 1'b0;
        send_item(directed_script[i].restart, directed_script[i].typed,
                  directed_script[i].typed_last);
      end
    end

    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      program_phase(phase == 2 ? 0 : (phase == 5 ? 1 : 2));
      cfg_we <= 1'b0;
      repeat (ItemsPerPhase) send_item($urandom_range(19) == 0, 1'b0, 1'b0);
    end

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
